// File: hw/rtl/sipq_pkg.sv
// Shared types and constants for the sorted-insert priority queue.
package sipq_pkg;

    localparam int CAPACITY = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_PUSHED  = 2'd0;
    localparam logic [1:0] ST_POPPED  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

// File: hw/rtl/sipq_cell.sv
// One storage cell of the sorted queue: holds an entry, shifts or loads.
module sipq_cell (
    input  logic               i_clk,
    input  sipq_pkg::t_cell_ctl i_ctl,
    input  sipq_pkg::t_entry   i_new,
    input  sipq_pkg::t_entry   i_left,
    input  sipq_pkg::t_entry   i_right,
    input  logic               i_ins_left,
    input  logic               i_occupied,
    output sipq_pkg::t_entry   o_entry,
    output logic               o_ins
);
    import sipq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // insertion point at or before this cell: empty, or stored priority larger
    assign o_ins   = !i_occupied || (r_entry.prio > i_new.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (i_ins_left) begin
                n_entry = i_left;
            end else if (o_ins) begin
                n_entry = i_new;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: hw/rtl/sorted_insert_priority_queue.sv
// Top level of the sorted-insert priority queue: cell row, count and result register.
//
// Usage notes
// - Input channel (i_valid / o_ready) carries operation, element, priority_req.
//   Operation 0 pushes the element, 1 pops the front entry (smallest priority;
//   equal priorities leave in arrival order).
// - Output channel (o_valid / i_ready) returns one result per input transfer:
//   status (pushed, popped, push dropped when full, pop on empty), the popped
//   entry (zero otherwise) and the entry count after the operation.
// - Every cell compares its stored priority with the new one and shifts left,
//   right or loads in the same cycle, so an operation updates the whole row at once.
// - Latency: the result is shown the cycle after the input transfer.
// - Throughput: one item per cycle while the receiver takes results; the
//   result register parts the two sides, so a new item is taken whenever the
//   held result leaves in the same cycle.
// - Receiver stall: the result holds in its register and o_ready drops until
//   it is taken; no item is lost.
// - Reset (i_rst_n low, synchronous) empties the queue and clears o_valid;
//   cell contents are left as they are and only read below the count.
module sorted_insert_priority_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic signed [sipq_pkg::DATA_W-1:0]  i_element,
    input  logic signed [sipq_pkg::DATA_W-1:0]  i_priority_req,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic        [1:0]                   o_status,
    output logic signed [sipq_pkg::DATA_W-1:0]  o_popped_element,
    output logic signed [sipq_pkg::DATA_W-1:0]  o_popped_priority,
    output logic        [sipq_pkg::COUNT_W-1:0] o_entry_count
);
    import sipq_pkg::*;

    logic                     r_out_valid;
    logic [1:0]               r_status;
    t_entry                   r_popped;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [1:0]               n_status;
    t_entry                   n_popped;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    t_cell_ctl                w_ctl;
    t_entry                   w_new;
    t_entry                   w_entry [CAPACITY];
    logic [CAPACITY-1:0]      w_ins;

    // result register frees up when empty or when its transfer completes
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    assign w_ctl.push = w_accept && (i_operation == OP_PUSH) && !w_full;
    assign w_ctl.pop  = w_accept && (i_operation == OP_POP) && !w_empty;

    assign w_new.value = i_element;
    assign w_new.prio  = i_priority_req;

    // cell row: entry 0 is the front of the queue
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_ins_left;

        if (g == 0) begin : g_first
            assign w_left     = w_new;
            assign w_ins_left = 1'b0;
        end else begin : g_mid
            assign w_left     = w_entry[g-1];
            assign w_ins_left = w_ins[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        sipq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_new      (w_new),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_ins_left (w_ins_left),
            .i_occupied (r_count > CNT_W'(g)),
            .o_entry    (w_entry[g]),
            .o_ins      (w_ins[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_popped = '0;
        if (i_operation == OP_PUSH) begin
            n_status = w_full ? ST_FULL : ST_PUSHED;
            if (!w_full) begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            n_status = w_empty ? ST_EMPTY : ST_POPPED;
            if (!w_empty) begin
                n_count  = r_count - CNT_W'(1);
                n_popped = w_entry[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_popped_element  = r_popped.value;
    assign o_popped_priority = r_popped.prio;
    assign o_entry_count     = COUNT_W'(r_count);

    // count never passes the capacity
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a committed push grows the count by one
    a_push_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not grow the count");

    // front two entries stay in priority order
    a_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) |-> w_entry[0].prio <= w_entry[1].prio)
        else $error("queue front out of order");

    // a pop on empty reports an empty queue
    a_empty_report : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> o_entry_count == '0)
        else $error("pop on empty with nonzero count");

endmodule

// File: bench/sorted_insert_priority_queue_tb.sv
// Self-checking bench for the sorted-insert priority queue: ordering, ties, full and empty.
module sorted_insert_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sipq_pkg::*;

    localparam int RANDOM_ITEMS = 830;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;

    // one result transfer as the block presents it
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
        logic [COUNT_W-1:0]       count;
    } t_queue_result;

    // Mirror of the queue contents plus the list of results still owed.
    class sorted_queue_checker;
        logic signed [DATA_W-1:0] held_value [CAPACITY];
        logic signed [DATA_W-1:0] held_prio  [CAPACITY];
        int                       held_count;
        t_queue_result            owed_results [$];
        int                       n_errors;

        function new();
            held_count = 0;
            n_errors   = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            n_errors++;
        endtask

        // Apply one accepted operation to the mirror and queue its result.
        function void note_transfer(input logic op, input logic signed [DATA_W-1:0] elem,
                                    input logic signed [DATA_W-1:0] prio);
            t_queue_result res;
            int            pos;
            int            i;
            res = '0;
            if (op == OP_PUSH) begin
                if (held_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    // first slot holding a strictly greater priority
                    pos = 0;
                    while (pos < held_count && held_prio[pos] <= prio)
                        pos++;
                    for (i = held_count; i > pos; i--) begin
                        held_value[i] = held_value[i-1];
                        held_prio[i]  = held_prio[i-1];
                    end
                    held_value[pos] = elem;
                    held_prio[pos]  = prio;
                    held_count++;
                    res.status = ST_PUSHED;
                end
            end else begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = held_value[0];
                    res.prio  = held_prio[0];
                    for (i = 0; i + 1 < held_count; i++) begin
                        held_value[i] = held_value[i+1];
                        held_prio[i]  = held_prio[i+1];
                    end
                    held_count--;
                    res.status = ST_POPPED;
                end
            end
            res.count = COUNT_W'(held_count);
            owed_results.push_back(res);
        endfunction

        task check_result(input t_queue_result got);
            t_queue_result want;
            if (owed_results.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
            end else begin
                want = owed_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.value !== want.value)
                    report_mismatch($sformatf("popped element %0d, want %0d",
                                              got.value, want.value));
                if (got.prio !== want.prio)
                    report_mismatch($sformatf("popped priority %0d, want %0d",
                                              got.prio, want.prio));
                if (got.count !== want.count)
                    report_mismatch($sformatf("entry count %0d, want %0d",
                                              got.count, want.count));
            end
        endtask
    endclass

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_valid        = 1'b0;
    logic                        o_ready;
    logic                        i_operation    = OP_PUSH;
    logic signed [DATA_W-1:0]    i_element      = '0;
    logic signed [DATA_W-1:0]    i_priority_req = '0;
    logic                        o_valid;
    logic                        i_ready        = 1'b0;
    logic        [1:0]           o_status;
    logic signed [DATA_W-1:0]    o_popped_element;
    logic signed [DATA_W-1:0]    o_popped_priority;
    logic        [COUNT_W-1:0]   o_entry_count;

    sorted_queue_checker checker_h = new();

    int  cycle_count  = 0;
    int  results_seen = 0;
    bit  tx_quiet     = 1'b0;   // sender offers back to back while set
    bit  rx_quiet     = 1'b0;   // receiver takes no random gaps while set
    int  rx_gap_left  = 0;
    int  hold_left    = 0;
    int  holds_done   = 0;

    sorted_insert_priority_queue u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_operation       (i_operation),
        .i_element         (i_element),
        .i_priority_req    (i_priority_req),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_popped_element  (o_popped_element),
        .o_popped_priority (o_popped_priority),
        .o_entry_count     (o_entry_count)
    );

    always #6 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(40, 20);
    endfunction

    // Priorities: a narrow band for plenty of ties, the corners, or anything.
    function automatic logic signed [DATA_W-1:0] pick_priority();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return $urandom_range(7);
        if (roll < 50) begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return '0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one item after an optional idle stretch and hold it until the
    // transfer happens; the mirror is updated at that edge.
    task automatic offer_item(input logic op, input logic signed [DATA_W-1:0] elem,
                              input logic signed [DATA_W-1:0] prio);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_element      <= elem;
        i_priority_req <= prio;
        do @(posedge i_clk); while (!o_ready);
        checker_h.note_transfer(op, elem, prio);
    endtask

    // Receiver: random stalls, quiet stretches, and two long hold-offs so the
    // result register fills and the input side has to wait.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (holds_done < 2 && results_seen >= 200 + 400 * holds_done) begin
            i_ready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
        end else if (rx_gap_left > 0) begin
            i_ready <= 1'b0;
            rx_gap_left--;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(99) < 2)
                rx_quiet = ~rx_quiet;
            if (!rx_quiet && $urandom_range(99) < 25)
                rx_gap_left = pick_gap();
        end
    end

    // Result side: every transfer is checked against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            checker_h.check_result({o_status, o_popped_element, o_popped_priority,
                                    o_entry_count});
            results_seen++;
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int n;
        int push_pct;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pop on empty, corner values, ties, fill to the brim,
        // push when full, drain completely, pop on empty again.
        offer_item(OP_POP,  32'sh1234_5678, 32'sh0BAD_F00D);
        offer_item(OP_PUSH, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        offer_item(OP_PUSH, 32'sh8000_0000, 32'sh8000_0000);
        offer_item(OP_PUSH, 32'sh0000_0000, 32'sh0000_0000);
        offer_item(OP_PUSH, -32'sd1,        -32'sd1);
        offer_item(OP_PUSH, 32'sd11,        32'sd5);
        offer_item(OP_PUSH, 32'sd22,        32'sd5);   // tie: must leave after 11
        offer_item(OP_PUSH, 32'sd33,        32'sd1);
        offer_item(OP_PUSH, 32'sd44,        32'sh7FFF_FFFF);
        offer_item(OP_PUSH, 32'sh5555_AAAA, 32'sh8000_0000); // queue full: dropped
        repeat (CAPACITY) offer_item(OP_POP, $urandom, $urandom);
        offer_item(OP_POP,  -32'sd1, -32'sd1);

        // Random: alternate fill, drain and balanced spells so the queue
        // keeps sweeping between empty and full.
        push_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 80;
                    1:       push_pct = 25;
                    default: push_pct = 55;
                endcase
            end
            if ($urandom_range(99) < 3)
                tx_quiet = ~tx_quiet;
            if ($urandom_range(99) < push_pct)
                offer_item(OP_PUSH, $urandom, pick_priority());
            else
                offer_item(OP_POP, $urandom, $urandom);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then keep the clock running to catch any stray transfer
        while (checker_h.owed_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (checker_h.n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
